// File: hw/rtl/atld_pkg.sv
// ----------------------------------------------------------------------------
// atld_pkg
// Types and constants shared by the adaptive threshold lock detector.
// ----------------------------------------------------------------------------
package atld_pkg;

   typedef logic [15:0] mag_type;     // unsigned Q2.14
   typedef logic [15:0] gain_type;    // unsigned Q2.14
   typedef logic [19:0] avg_type;     // unsigned Q2.18
   typedef logic [15:0] count_type;
   typedef logic [1:0]  mode_type;

   localparam mode_type MODE_ACQ    = 2'd0;
   localparam mode_type MODE_TRACK  = 2'd1;
   localparam mode_type MODE_LOCKED = 2'd2;

   localparam int LOCK_COUNT_DEF = 8;
   localparam int COUNT_MAX_DEF  = 65535;

   localparam gain_type GAIN_RESET = 16'd8192;   // 0.5

   // shared multiplier operand width; product is twice this
   localparam int MUL_W = 25;

   // floor(x / 10) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2**26
   localparam int                 DIV_SHIFT = 28;
   localparam logic [MUL_W-1:0]   DIV_RECIP = 25'd26843546;

   localparam mag_type            PEAK_FLOOR = 16'd16;     // 0.001 in Q2.14
   localparam logic [18:0]        MIN_THRESH = 19'd16384;  // 5*C must exceed this

   typedef struct packed {
      logic valid;    // commit one symbol decision
      logic passed;
   } upd_type;

   typedef struct packed {
      mode_type mode;
      logic     lock;
   } status_type;

endpackage

// File: hw/rtl/atld_if.sv
// ----------------------------------------------------------------------------
// atld channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atld_req_if;
   logic                valid;
   logic                ready;
   atld_pkg::mag_type   corr_magnitude;

   modport source (output valid, output corr_magnitude, input ready);
   modport sink   (input valid, input corr_magnitude, output ready);
endinterface

interface atld_rsp_if;
   logic                valid;
   logic                ready;
   atld_pkg::mode_type  lock_mode;
   logic                locked;
   logic                passed;

   modport source (output valid, output lock_mode, output locked, output passed,
                   input ready);
   modport sink   (input valid, input lock_mode, input locked, input passed,
                   output ready);
endinterface

interface atld_csr_if;
   logic                valid;
   logic                ready;
   atld_pkg::gain_type  lock_threshold_gain;

   modport source (output valid, output lock_threshold_gain, input ready);
   modport sink   (input valid, input lock_threshold_gain, output ready);
endinterface

// File: hw/rtl/adaptive_threshold_lock_detector.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_lock_detector
// Per-symbol lock detection against an adaptive correlation threshold.
// ----------------------------------------------------------------------------
// A request is taken only while idle, so the next one waits until this one has
//   passed the divide, average, C*Pf and compare steps; the sequencer drives one
//   shared multiplier three times per request (divide by 10, C*Pf, gain*avg).
// A finished response waits in its output register while the next request
//   is taken; the final step holds only if that register is still full.
// Reset (synchronous): idle, gain = 0.5, average/peak/count/mode/lock cleared.
// ----------------------------------------------------------------------------
module adaptive_threshold_lock_detector #(
   parameter int LOCK_COUNT = atld_pkg::LOCK_COUNT_DEF,
   parameter int COUNT_MAX  = atld_pkg::COUNT_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   atld_req_if.sink    req_if,
   atld_rsp_if.source  rsp_if,
   atld_csr_if.sink    csr_if
);
   import atld_pkg::*;

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request
   localparam logic [2:0] S_DIV  = 3'd1;  // multiply sum by 1/10
   localparam logic [2:0] S_AVG  = 3'd2;  // take new average/peak, start C*Pf
   localparam logic [2:0] S_CP   = 3'd3;  // hold C*Pf, start gain*avg
   localparam logic [2:0] S_CMP  = 3'd4;  // compare, commit, load response

   logic [2:0]        state_ff, state_in;

   // configuration
   gain_type          gain_ff;

   // datapath registers
   mag_type           c_ff;
   logic [MUL_W-1:0]  sum_ff;      // 9*A + 16*C, fits 25 bits
   avg_type           avg_ff;
   mag_type           peak_ff;
   logic [31:0]       cp_ff;       // C * floored peak

   // response register
   logic              rsp_valid_ff;
   mode_type          rsp_state_ff;
   logic              rsp_locked_ff;
   logic              rsp_passed_ff;

   // shared multiplier
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] prod;

   logic              req_take;
   logic              out_free;
   logic [MUL_W-1:0]  sum_in;
   mag_type           peak_new;
   mag_type           peak_flr;
   logic [18:0]       c_x5;
   logic              pass;
   upd_type           upd;
   status_type        status_nxt;

   assign csr_if.ready = 1'b1;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // 9*A + 16*C with shifts and adds
   assign sum_in = {2'b00, avg_ff, 3'b000} + {5'b00000, avg_ff} +
                   {5'b00000, req_if.corr_magnitude, 4'b0000};

   assign peak_new = (c_ff > peak_ff) ? c_ff : peak_ff;
   assign peak_flr = (peak_new < PEAK_FLOOR) ? PEAK_FLOOR : peak_new;

   // both sides of the test are exact integers: 5C > 16384 and 16*C*Pf > G*A
   assign c_x5 = {1'b0, c_ff, 2'b00} + {3'b000, c_ff};
   assign pass = (c_x5 > MIN_THRESH) && ({cp_ff, 4'b0000} > prod[35:0]);

   always_comb begin
      unique case (state_ff)
         S_DIV: begin
            mul_a = sum_ff;
            mul_b = DIV_RECIP;
         end
         S_AVG: begin
            mul_a = {9'd0, c_ff};
            mul_b = {9'd0, peak_flr};
         end
         // operands stay put while the compare waits, so gain*avg holds
         S_CP, S_CMP: begin
            mul_a = {9'd0, gain_ff};
            mul_b = {5'd0, avg_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   atld_mul_unit #(
      .W (MUL_W)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_DIV;
         S_DIV:   state_in = S_AVG;
         S_AVG:   state_in = S_CP;
         S_CP:    state_in = S_CMP;
         S_CMP:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign upd.valid  = (state_ff == S_CMP) && out_free;
   assign upd.passed = pass;

   atld_lock_track #(
      .LOCK_COUNT (LOCK_COUNT),
      .COUNT_MAX  (COUNT_MAX)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .status_nxt (status_nxt)
   );

   // control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= GAIN_RESET;
         avg_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid && csr_if.ready) begin
            gain_ff <= csr_if.lock_threshold_gain;
         end
         if (state_ff == S_AVG) begin
            avg_ff  <= prod[DIV_SHIFT+19:DIV_SHIFT];
            peak_ff <= peak_new;
         end
         if (upd.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         c_ff   <= req_if.corr_magnitude;
         sum_ff <= sum_in;
      end
      if (state_ff == S_CP) begin
         cp_ff <= prod[31:0];
      end
      if (upd.valid) begin
         rsp_state_ff  <= status_nxt.mode;
         rsp_locked_ff <= status_nxt.lock;
         rsp_passed_ff <= pass;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.lock_mode = rsp_state_ff;
   assign rsp_if.locked    = rsp_locked_ff;
   assign rsp_if.passed    = rsp_passed_ff;

endmodule

// File: hw/rtl/atld_mul_unit.sv
// ----------------------------------------------------------------------------
// atld_mul_unit
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module atld_mul_unit #(
   parameter int W = atld_pkg::MUL_W
) (
   input  logic           clock,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic [2*W-1:0] prod_ff
);

   logic [2*W-1:0] prod_in;

   assign prod_in = {{W{1'b0}}, op_a} * {{W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: hw/rtl/atld_lock_track.sv
// ----------------------------------------------------------------------------
// atld_lock_track
// Hit counter, sync mode and lock flag, advanced once per symbol decision.
// ----------------------------------------------------------------------------
module atld_lock_track #(
   parameter int LOCK_COUNT = atld_pkg::LOCK_COUNT_DEF,
   parameter int COUNT_MAX  = atld_pkg::COUNT_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  atld_pkg::upd_type     upd,
   output atld_pkg::status_type  status_nxt
);
   import atld_pkg::*;

   localparam count_type   CNT_MAX = 16'(COUNT_MAX);
   localparam count_type   LOCK1   = 16'(LOCK_COUNT);
   localparam logic [16:0] LOCK2   = 17'(2 * LOCK_COUNT);

   count_type hit_ff, hit_in;
   mode_type  mode_ff, mode_in;
   logic      lock_ff, lock_in;

   always_comb begin
      hit_in  = hit_ff;
      mode_in = mode_ff;
      lock_in = lock_ff;
      if (upd.valid) begin
         if (upd.passed) begin
            if (hit_ff < CNT_MAX) begin
               hit_in = hit_ff + 16'd1;
            end
            if (hit_in >= LOCK1) begin
               lock_in = 1'b1;
               if (mode_ff == MODE_ACQ) begin
                  mode_in = MODE_TRACK;
               end
               // acquisition can go straight through to locked
               if (mode_in == MODE_TRACK && {1'b0, hit_in} >= LOCK2) begin
                  mode_in = MODE_LOCKED;
               end
            end
         end else begin
            if (hit_ff != '0) begin
               hit_in = hit_ff - 16'd1;
            end
            if (hit_in == '0 && mode_ff == MODE_LOCKED) begin
               mode_in = MODE_TRACK;
               lock_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= '0;
         mode_ff <= MODE_ACQ;
         lock_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         mode_ff <= mode_in;
         lock_ff <= lock_in;
      end
   end

   assign status_nxt.mode = mode_in;
   assign status_nxt.lock = lock_in;

endmodule

// File: hw/rtl/atld_checker.sv
// ----------------------------------------------------------------------------
// atld_checker
// Port-level assertions for the lock detector, bound to the top level.
// ----------------------------------------------------------------------------
module atld_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input atld_pkg::mode_type  rsp_lock_mode,
   input logic                rsp_locked
);
   import atld_pkg::*;

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an accepted request keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // locked state always carries the lock flag
   a_locked_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_mode == MODE_LOCKED |-> rsp_locked)
      else $error("locked state without lock flag");

   // acquisition never shows the lock flag
   a_acq_unlocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_mode == MODE_ACQ |-> !rsp_locked)
      else $error("lock flag set during acquisition");

endmodule

bind adaptive_threshold_lock_detector atld_checker u_atld_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_lock_mode (rsp_if.lock_mode),
   .rsp_locked    (rsp_if.locked)
);

// File: tb/tb_adaptive_threshold_lock_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_threshold_lock_detector
// Self-checking bench for the adaptive threshold lock detector. Magnitudes go
// in over the request channel and a cycle-free tracker of the detector state
// predicts each response. The sender works in bursts and the response sink
// stalls on changing patterns. The gain register is only written while idle.
// ----------------------------------------------------------------------------
module tb_adaptive_threshold_lock_detector;
   import atld_pkg::*;

   localparam int LOCK_HITS     = LOCK_COUNT_DEF;
   localparam int HIT_CEILING   = COUNT_MAX_DEF;
   localparam int SETTLE_CYCLES = 8;        // a bit over the request-to-response latency
   localparam int HOLD_CYCLES   = 150;      // long response stall
   localparam int CYCLE_LIMIT   = 300000;
   localparam int REPORT_LIMIT  = 10;

   // one response as the block reports it
   typedef struct packed {
      mode_type lock_mode;
      logic     locked;
      logic     passed;
   } sync_report_type;

   // response sink behavior, changed at the end of each random stretch
   typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_pattern_type;

   logic clock;
   logic reset;

   atld_req_if req_ch ();
   atld_rsp_if rsp_ch ();
   atld_csr_if csr_ch ();

   adaptive_threshold_lock_detector #(
      .LOCK_COUNT (LOCK_HITS),
      .COUNT_MAX  (HIT_CEILING)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // ------------------------------------------------------------------------
   // Tracker state: mirrors the detector after every accepted request.
   // ------------------------------------------------------------------------
   mode_type trk_mode  = MODE_ACQ;
   int       trk_hits  = 0;
   logic     trk_flag  = 1'b0;
   avg_type  trk_avg   = '0;
   mag_type  trk_peak  = '0;
   gain_type trk_gain  = GAIN_RESET;

   sync_report_type reports_due[$];        // predicted responses, oldest first

   // run statistics
   int items_sent   = 0;
   int hits_seen    = 0;
   int lock_entries = 0;
   int lock_losses  = 0;
   int gain_writes  = 0;
   int mismatches   = 0;
   int cycle_count  = 0;

   // sender pacing: burst length left and the longest gap between bursts
   int burst_left = 0;
   int gap_max    = 6;

   // a change of this counter asks the sink for one long hold-off
   int rsp_hold_req = 0;

   // ------------------------------------------------------------------------
   // Predict the response to one magnitude and advance the tracker.
   // The pass test is exact integer math in Q2.14 / Q2.18.
   // ------------------------------------------------------------------------
   function automatic sync_report_type predict_sync_report(input mag_type c);
      logic [63:0]     corr_side;
      logic [63:0]     gain_side;
      mag_type         floored_peak;
      logic            hit;
      sync_report_type r;
      // 0.9/0.1 average, kept in Q2.18 so the magnitude enters times 16
      trk_avg = avg_type'((64'(trk_avg) * 9 + 64'(c) * 16) / 10);
      if (c > trk_peak)
         trk_peak = c;
      floored_peak = (trk_peak < PEAK_FLOOR) ? PEAK_FLOOR : trk_peak;
      corr_side = 64'(c) * 64'(floored_peak) * 16;
      gain_side = 64'(trk_gain) * 64'(trk_avg);
      // above 0.2 and above gain*avg/peak, both strict
      hit = (64'(c) * 5 > 64'(MIN_THRESH)) && (corr_side > gain_side);
      if (hit) begin
         hits_seen++;
         if (trk_hits < HIT_CEILING)
            trk_hits++;
         if (trk_hits >= LOCK_HITS) begin
            trk_flag = 1'b1;
            if (trk_mode == MODE_ACQ)
               trk_mode = MODE_TRACK;
            if (trk_mode == MODE_TRACK && trk_hits >= 2 * LOCK_HITS) begin
               trk_mode = MODE_LOCKED;
               lock_entries++;
            end
         end
      end else begin
         if (trk_hits > 0)
            trk_hits--;
         // only the locked state gives up the flag at zero count
         if (trk_hits == 0 && trk_mode == MODE_LOCKED) begin
            trk_mode = MODE_TRACK;
            trk_flag = 1'b0;
            lock_losses++;
         end
      end
      r.lock_mode = trk_mode;
      r.locked    = trk_flag;
      r.passed    = hit;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, reports_due.size());
         $display("FAIL adaptive_threshold_lock_detector");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Response sink. Ready follows a pattern that changes every stretch;
   // a hold-off request parks ready low for HOLD_CYCLES, counted here.
   // ------------------------------------------------------------------------
   initial begin
      sink_pattern_type pattern;
      int               stretch;
      int               phase;
      int               hold_left;
      int               hold_seen;
      pattern   = SINK_OPEN;
      stretch   = 0;
      phase     = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != rsp_hold_req) begin
            hold_seen = rsp_hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (stretch == 0) begin
               pattern = sink_pattern_type'($urandom_range(2, 0));
               stretch = $urandom_range(80, 20);
            end
            stretch--;
            phase++;
            case (pattern)
               SINK_OPEN:   rsp_ch.ready <= 1'b1;
               SINK_RANDOM: rsp_ch.ready <= ($urandom_range(9, 0) > 2);
               default:     rsp_ch.ready <= (phase % 3 == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: every accepted response against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      sync_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"[%0t] response with nothing outstanding: ",
                         "state %0d lock %0b pass %0b"},
                        $realtime, rsp_ch.lock_mode, rsp_ch.locked, rsp_ch.passed);
         end else begin
            want = reports_due.pop_front();
            if (rsp_ch.lock_mode !== want.lock_mode || rsp_ch.locked !== want.locked ||
                rsp_ch.passed !== want.passed) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"[%0t] mismatch: expected state %0d lock %0b pass %0b, ",
                            "got state %0d lock %0b pass %0b"},
                           $realtime, want.lock_mode, want.locked, want.passed,
                           rsp_ch.lock_mode, rsp_ch.locked, rsp_ch.passed);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------------

   // Offer one magnitude, wait for the handshake, record the prediction.
   // Valid stays high inside a burst; the burst end drops it for a gap when gap_max is nonzero.
   task automatic send_magnitude(input mag_type c);
      int gap;
      req_ch.valid          <= 1'b1;
      req_ch.corr_magnitude <= c;
      do @(posedge clock); while (!req_ch.ready);
      reports_due.push_back(predict_sync_report(c));
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         if (gap_max > 0) begin
            gap = $urandom_range(gap_max, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and let every outstanding response drain.
   task automatic wait_for_reports();
      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Gain writes only happen with the detector idle.
   task automatic write_lock_gain(input gain_type g);
      wait_for_reports();
      csr_ch.valid               <= 1'b1;
      csr_ch.lock_threshold_gain <= g;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      trk_gain = g;
      gain_writes++;
   endtask

   // magnitude that always clears the threshold when gain <= 1.0
   function automatic mag_type strong_magnitude();
      return mag_type'($urandom_range(65535, 20000));
   endfunction

   // magnitude at or below 0.2, never a pass
   function automatic mag_type weak_magnitude();
      return mag_type'($urandom_range(3276, 0));
   endfunction

   // full range, with extra weight just around the 0.2 floor
   function automatic mag_type noise_magnitude();
      if ($urandom_range(4, 0) == 0)
         return mag_type'($urandom_range(3400, 3150));
      return mag_type'($urandom_range(65535, 0));
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Field extremes, the 0.2 boundary, peak floor, fail at zero count,
   // and gain extremes including alternating bit patterns.
   task automatic test_threshold_edges();
      send_magnitude(16'd0);          // fail with count at zero, peak floored
      send_magnitude(16'd1);
      send_magnitude(16'd3276);       // 5*C just below the floor
      send_magnitude(16'd3277);       // first value over 0.2
      send_magnitude(16'hFFFF);
      send_magnitude(16'd3276);
      write_lock_gain(16'h0000);      // threshold collapses to the 0.2 floor
      send_magnitude(16'd3276);
      send_magnitude(16'd3277);
      send_magnitude(16'h5555);
      send_magnitude(16'hAAAA);
      write_lock_gain(16'hFFFF);      // near 4.0 * avg / peak
      send_magnitude(16'hFFFF);
      send_magnitude(16'h8000);
      send_magnitude(16'd0);
      write_lock_gain(16'h5555);
      send_magnitude(16'hAAAA);
      write_lock_gain(16'hAAAA);
      send_magnitude(16'h5555);
      wait_for_reports();
   endtask

   // Strong and weak runs with a little noise: climbs through tracking into
   // locked, drops back at zero count, and also stalls in tracking with the
   // flag held when a short climb fades out.
   task automatic test_lock_cycles();
      int strong_len;
      int weak_len;
      write_lock_gain(GAIN_RESET);
      gap_max = 6;
      for (int round = 0; round < 12; round++) begin
         if (round == 6) begin
            write_lock_gain(gain_type'($urandom_range(16384, 0)));
            gap_max = 0;               // a stretch with no request gaps
         end
         if (round == 9)
            gap_max = 10;
         strong_len = $urandom_range(24, 8);
         weak_len   = $urandom_range(24, 4);
         for (int i = 0; i < strong_len; i++)
            send_magnitude(($urandom_range(9, 0) == 0) ? noise_magnitude() :
                           strong_magnitude());
         for (int i = 0; i < weak_len; i++)
            send_magnitude(($urandom_range(9, 0) == 0) ? noise_magnitude() :
                           weak_magnitude());
      end
      wait_for_reports();
   endtask

   // Long response hold-off while requests keep coming back to back,
   // so the output register fills and the request side stalls.
   task automatic test_output_backpressure();
      gap_max    = 0;
      burst_left = 0;
      rsp_hold_req <= rsp_hold_req + 1;
      for (int i = 0; i < 30; i++)
         send_magnitude(strong_magnitude());
      wait_for_reports();
      gap_max = 6;
   endtask

   // Full-range magnitudes across several gains, pacing varied per phase.
   task automatic test_random_magnitudes();
      gain_type gain_pick;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       gain_pick = 16'hFFFF;
            1:       gain_pick = 16'd16384;   // 1.0
            3:       gain_pick = 16'h0000;
            default: gain_pick = gain_type'($urandom_range(65535, 0));
         endcase
         write_lock_gain(gain_pick);
         gap_max = (phase % 2 == 0) ? 0 : $urandom_range(12, 2);
         for (int i = 0; i < 40; i++)
            send_magnitude(noise_magnitude());
      end
      wait_for_reports();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                      <= 1'b1;
      req_ch.valid               <= 1'b0;
      req_ch.corr_magnitude      <= '0;
      csr_ch.valid               <= 1'b0;
      csr_ch.lock_threshold_gain <= GAIN_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_threshold_edges();
      test_lock_cycles();
      test_output_backpressure();
      test_random_magnitudes();
      wait_for_reports();

      $display("Ran %0d requests under %0d gain writes: %0d threshold passes,",
               items_sent, gain_writes, hits_seen);
      $display("%0d entries into locked, %0d lock losses, %0d mismatches.",
               lock_entries, lock_losses, mismatches);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("PASS adaptive_threshold_lock_detector");
      end else begin
         $display("FAIL adaptive_threshold_lock_detector");
      end
      $finish;
   end

endmodule
